@@ src/sprd_pkg.sv @@
// Shared types and constants for the sprite run-length word decoder.
package sprd_pkg;

	localparam int unsigned MAX_DIM_DEF = 4096;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [15:0] WORD_END_ROW   = 16'h0000;
	localparam logic [15:0] WORD_END_IMAGE = 16'h0100;
	localparam logic [15:0] WORD_SKIP      = 16'h0200;

	typedef enum logic [1:0] {
		KIND_FILL    = 2'd0,
		KIND_LITERAL = 2'd1,
		KIND_DONE    = 2'd2
	} span_kind_t;

	typedef enum logic [1:0] {
		PH_CONTROL = 2'd0,
		PH_SKIP    = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

endpackage

@@ src/sprd_word_if.sv @@
// Coded word channel: valid/ready handshake with one 16-bit word and a restart flag.
interface sprd_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_word;
	logic        restart;

	modport source (output valid, output code_word, output restart, input ready);
	modport sink (input valid, input code_word, input restart, output ready);
endinterface

@@ src/sprd_span_if.sv @@
// Span channel: valid/ready handshake carrying one clipped span item.
interface sprd_span_if;
	logic        valid;
	logic        ready;
	logic [1:0]  span_kind;
	logic [11:0] col;
	logic [11:0] row;
	logic [7:0]  span_length;
	logic [7:0]  first_index;
	logic [7:0]  second_index;

	modport source (
		output valid, output span_kind, output col, output row,
		output span_length, output first_index, output second_index,
		input ready
	);
	modport sink (
		input valid, input span_kind, input col, input row,
		input span_length, input first_index, input second_index,
		output ready
	);
endinterface

@@ src/sprite_rle_word_decoder.sv @@
// Top level: run-length sprite decoder turning coded words into clipped spans.
//
// Usage: coded 16-bit words enter on the words channel, one item per word,
// with restart set on the first word of a new image. Decoded spans leave on
// the spans channel: fill spans, literal pairs (one or two pixels) and at most one
// finished item per image. Words that produce no span give no output item.
// Image width and height are set through the write port (index 0 width,
// index 1 height) while no item is in flight.
// Path: a word is captured in the input register, and its span is decoded
// from there into the output register.
// Throughput: one word per cycle unless stalled; the decode state update is a
// single pass of small adds and compares between input and output registers.
// Stall: when spans.ready is low, the output register holds its span and the
// input register holds the next word; words.ready drops once both are full.
// Reset: state returns to image finished, width and height to 1; every word
// is dropped until one arrives with restart set.
module sprite_rle_word_decoder
	import sprd_pkg::*;
#(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sprd_word_if.sink             words,
	sprd_span_if.source           spans,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned DIM_W = $clog2(MAX_DIM);
	localparam int unsigned CW = ((DIM_W > 12) ? DIM_W : 12) + 1;
	localparam logic [CW-1:0] COL_MAX = CW'(MAX_DIM - 1);

	// configuration
	logic [11:0] image_width_q;
	logic [11:0] image_height_q;

	// input register
	logic        valid_s1;
	logic [15:0] word_s1;
	logic        restart_s1;

	// decode state
	logic [11:0]      row_q;
	logic [DIM_W-1:0] col_q;
	phase_t           phase_q;
	logic [7:0]       left_q;
	logic             done_q;

	// output register
	logic        ovalid_q;
	span_kind_t  kind_q;
	logic [11:0] ocol_q;
	logic [11:0] orow_q;
	logic [7:0]  olen_q;
	logic [7:0]  ofirst_q;
	logic [7:0]  osecond_q;

	logic adv;
	assign adv = !ovalid_q || spans.ready;
	assign words.ready = !valid_s1 || adv;

	// next-state values
	logic [11:0]      row_d;
	logic [DIM_W-1:0] col_d;
	phase_t           phase_d;
	logic [7:0]       left_d;
	logic             done_d;
	logic             emit_d;
	span_kind_t       kind_d;
	logic [11:0]      ocol_d;
	logic [7:0]       olen_d;
	logic [7:0]       ofirst_d;
	logic [7:0]       osecond_d;

	function automatic logic [DIM_W-1:0] col_add(input logic [DIM_W-1:0] c,
			input logic [7:0] n);
		logic [CW:0] s;
		s = (CW+1)'(c) + (CW+1)'(n);
		if (s > (CW+1)'(COL_MAX))
			s = (CW+1)'(COL_MAX);
		return s[DIM_W-1:0];
	endfunction

	function automatic logic [7:0] clip_len(input logic [DIM_W-1:0] start,
			input logic [7:0] n, input logic [11:0] width);
		logic [CW-1:0] w;
		logic [CW-1:0] room;
		w = (CW'(width) > COL_MAX) ? COL_MAX : CW'(width);
		if (CW'(start) >= w)
			return 8'd0;
		room = w - CW'(start);
		if (CW'(n) > room)
			return room[7:0];
		return n;
	endfunction

	// finished items report row zero
	function automatic logic [11:0] fin_row(input span_kind_t k, input logic [11:0] r);
		return (k == KIND_DONE) ? 12'd0 : r;
	endfunction

	always_comb begin
		logic [7:0]       lo;
		logic [7:0]       hi;
		logic             fin;
		logic [1:0]       n_lit;
		logic [7:0]       len;
		logic [31:0]      col_ext;
		lo = word_s1[7:0];
		hi = word_s1[15:8];
		fin = 1'b0;
		n_lit = 2'd0;
		len = 8'd0;
		col_ext = 32'(col_q);
		row_d = row_q;
		col_d = col_q;
		phase_d = phase_q;
		left_d = left_q;
		done_d = done_q;
		emit_d = 1'b0;
		kind_d = KIND_FILL;
		ocol_d = col_ext[11:0];
		olen_d = 8'd0;
		ofirst_d = 8'd0;
		osecond_d = 8'd0;

		if (restart_s1) begin
			col_d = '0;
			phase_d = PH_CONTROL;
			left_d = 8'd0;
			done_d = 1'b0;
			if (image_height_q == 12'd0)
				fin = 1'b1;
			else
				row_d = image_height_q - 12'd1;
		end

		if (!fin && !done_d) begin
			unique case (phase_d)
				PH_SKIP: begin
					col_d = col_add(col_d, lo);
					if (12'(hi) > row_d) begin
						fin = 1'b1;
					end else begin
						row_d = row_d - 12'(hi);
						phase_d = PH_CONTROL;
					end
				end
				PH_LITERAL: begin
					n_lit = (left_d >= 8'd2) ? 2'd2 : left_d[1:0];
					len = clip_len(col_d, 8'(n_lit), image_width_q);
					col_ext = 32'(col_d);
					left_d = left_d - 8'(n_lit);
					if (left_d == 8'd0)
						phase_d = PH_CONTROL;
					col_d = col_add(col_d, 8'(n_lit));
					if (len != 8'd0) begin
						emit_d = 1'b1;
						kind_d = KIND_LITERAL;
						ocol_d = col_ext[11:0];
						olen_d = len;
						ofirst_d = lo;
						osecond_d = (len == 8'd2) ? hi : 8'd0;
					end
				end
				default: begin
					phase_d = PH_CONTROL;
					priority if (word_s1 == WORD_END_ROW) begin
						if (row_d == 12'd0) begin
							fin = 1'b1;
						end else begin
							row_d = row_d - 12'd1;
							col_d = '0;
						end
					end else if (word_s1 == WORD_END_IMAGE) begin
						fin = 1'b1;
					end else if (word_s1 == WORD_SKIP) begin
						phase_d = PH_SKIP;
					end else if (lo != 8'd0) begin
						len = clip_len(col_d, lo, image_width_q);
						col_ext = 32'(col_d);
						col_d = col_add(col_d, lo);
						if (len != 8'd0) begin
							emit_d = 1'b1;
							kind_d = KIND_FILL;
							ocol_d = col_ext[11:0];
							olen_d = len;
							ofirst_d = hi;
						end
					end else if (hi != 8'd0) begin
						left_d = hi;
						phase_d = PH_LITERAL;
					end
				end
			endcase
		end

		// finished image: report once and drop words until restart
		if (fin) begin
			done_d = 1'b1;
			phase_d = PH_CONTROL;
			left_d = 8'd0;
			emit_d = 1'b1;
			kind_d = KIND_DONE;
			ocol_d = 12'd0;
			olen_d = 8'd0;
			ofirst_d = 8'd0;
			osecond_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= 12'd1;
			image_height_q <= 12'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q <= cfg_wdata;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.ready) begin
			valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (words.ready && words.valid) begin
			word_s1 <= words.code_word;
			restart_s1 <= words.restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 12'd0;
			col_q <= '0;
			phase_q <= PH_CONTROL;
			left_q <= 8'd0;
			done_q <= 1'b1;
			ovalid_q <= 1'b0;
		end else if (adv) begin
			ovalid_q <= valid_s1 && emit_d;
			if (valid_s1) begin
				row_q <= row_d;
				col_q <= col_d;
				phase_q <= phase_d;
				left_q <= left_d;
				done_q <= done_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit_d) begin
			kind_q <= kind_d;
			ocol_q <= ocol_d;
			orow_q <= fin_row(kind_d, row_d);
			olen_q <= olen_d;
			ofirst_q <= ofirst_d;
			osecond_q <= osecond_d;
		end
	end

	assign spans.valid = ovalid_q;
	assign spans.span_kind = kind_q;
	assign spans.col = ocol_q;
	assign spans.row = orow_q;
	assign spans.span_length = olen_q;
	assign spans.first_index = ofirst_q;
	assign spans.second_index = osecond_q;

endmodule

@@ tb/tb_sprite_rle_word_decoder.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sprite run-length word decoder: directed and random streams.
module tb_sprite_rle_word_decoder;
	import sprd_pkg::*;

	localparam int unsigned COL_MAX = MAX_DIM_DEF - 1;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned HOLD_OFF_CYCLES = 250;
	localparam int unsigned MAX_REPORTS = 30;

	typedef struct packed {
		span_kind_t  kind;
		logic [11:0] col;
		logic [11:0] row;
		logic [7:0]  len;
		logic [7:0]  first_idx;
		logic [7:0]  second_idx;
	} span_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	sprd_word_if code_ch ();
	sprd_span_if span_ch ();

	sprite_rle_word_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.words     (code_ch),
		.spans     (span_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the decoder: size settings and parse state
	logic [11:0] dim_width;
	logic [11:0] dim_height;
	int unsigned row_pos;
	int unsigned col_pos;
	int unsigned run_left;
	phase_t parse_ph;
	bit image_closed;

	span_t expected_spans[$];
	int unsigned mismatches = 0;
	int unsigned words_decoded = 0;
	int unsigned settings_used = 0;
	int unsigned fill_seen = 0;
	int unsigned literal_seen = 0;
	int unsigned done_seen = 0;
	int unsigned quiet_cycles = 0;
	bit steady = 1'b0;
	bit wide_rows = 1'b0;
	bit hold_off_req = 1'b0;

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void advance_col(input int unsigned n);
		col_pos = (col_pos + n > COL_MAX) ? COL_MAX : col_pos + n;
	endfunction

	function automatic int unsigned clipped_len(input int unsigned start, input int unsigned n);
		int unsigned w;
		w = (dim_width > COL_MAX) ? COL_MAX : dim_width;
		if (start >= w)
			return 0;
		return (n > w - start) ? w - start : n;
	endfunction

	function automatic void close_image(output span_t s);
		image_closed = 1'b1;
		parse_ph = PH_CONTROL;
		run_left = 0;
		s = '{KIND_DONE, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0};
	endfunction

	// Span caused by one coded word, if any; updates the shadow state
	function automatic bit decode_word(input logic [15:0] w, input bit rs, output span_t s);
		int unsigned lo;
		int unsigned hi;
		int unsigned n;
		int unsigned start;
		int unsigned len;
		lo = w[7:0];
		hi = w[15:8];
		s = '{KIND_FILL, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0};
		if (rs) begin
			col_pos = 0;
			parse_ph = PH_CONTROL;
			run_left = 0;
			image_closed = 1'b0;
			if (dim_height == 0) begin
				close_image(s);
				return 1'b1;
			end
			row_pos = dim_height - 1;
		end
		if (image_closed)
			return 1'b0;
		if (parse_ph == PH_SKIP) begin
			advance_col(lo);
			if (hi > row_pos) begin
				close_image(s);
				return 1'b1;
			end
			row_pos -= hi;
			parse_ph = PH_CONTROL;
			return 1'b0;
		end
		if (parse_ph == PH_LITERAL) begin
			n = (run_left >= 2) ? 2 : run_left;
			start = col_pos;
			len = clipped_len(start, n);
			run_left -= n;
			if (run_left == 0)
				parse_ph = PH_CONTROL;
			advance_col(n);
			if (len == 0)
				return 1'b0;
			s = '{KIND_LITERAL, 12'(start), 12'(row_pos), 8'(len), 8'(lo),
				(len == 2) ? 8'(hi) : 8'd0};
			return 1'b1;
		end
		parse_ph = PH_CONTROL;
		if (w == WORD_END_ROW) begin
			if (row_pos == 0) begin
				close_image(s);
				return 1'b1;
			end
			row_pos -= 1;
			col_pos = 0;
			return 1'b0;
		end
		if (w == WORD_END_IMAGE) begin
			close_image(s);
			return 1'b1;
		end
		if (w == WORD_SKIP) begin
			parse_ph = PH_SKIP;
			return 1'b0;
		end
		if (lo != 0) begin
			start = col_pos;
			len = clipped_len(start, lo);
			advance_col(lo);
			if (len == 0)
				return 1'b0;
			s = '{KIND_FILL, 12'(start), 12'(row_pos), 8'(len), 8'(hi), 8'd0};
			return 1'b1;
		end
		if (hi != 0) begin
			run_left = hi;
			parse_ph = PH_LITERAL;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [11:0] got,
			input logic [11:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
	endtask

	// Offer one word after a random gap; leave valid high for the next item
	task automatic send_word(input logic [15:0] w, input bit rs);
		int unsigned gap;
		span_t s;
		gap = pick_gap();
		if (gap > 0) begin
			code_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		code_ch.valid <= 1'b1;
		code_ch.code_word <= w;
		code_ch.restart <= rs;
		do @(posedge clk); while (code_ch.ready !== 1'b1);
		if (rs || !image_closed)
			words_decoded++;
		if (decode_word(w, rs, s))
			expected_spans = {expected_spans, s};
	endtask

	// Drop valid and wait until every span is out and the pipeline is empty
	task automatic settle();
		code_ch.valid <= 1'b0;
		while (expected_spans.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_dims(input logic [11:0] w, input logic [11:0] h);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		dim_width = w;
		dim_height = h;
		settings_used++;
	endtask

	// Mostly well-formed token streams with random content, some noise and cut-off runs
	task automatic send_random_words(input int unsigned count);
		int unsigned stop_at;
		int unsigned r;
		int unsigned cnt;
		int unsigned lo;
		int unsigned hi;
		bit rs;
		stop_at = words_decoded + count;
		rs = 1'b1;
		while (words_decoded < stop_at) begin
			if (image_closed && $urandom_range(0, 9) != 0)
				rs = 1'b1;
			if ($urandom_range(0, 49) == 0)
				rs = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 40) begin
				if (wide_rows && $urandom_range(0, 1) == 1)
					lo = 255;
				else if ($urandom_range(0, 3) == 0)
					lo = $urandom_range(1, 255);
				else
					lo = $urandom_range(1, 12);
				send_word({8'($urandom_range(0, 255)), 8'(lo)}, rs);
			end else if (r < 58) begin
				cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 255)
					: $urandom_range(3, 9);
				send_word({8'(cnt), 8'h00}, rs);
				// cut some runs short so that the next token is read as pixels
				cnt = (cnt + 1) / 2;
				if ($urandom_range(0, 9) == 0)
					cnt = $urandom_range(0, cnt);
				repeat (cnt) send_word(16'($urandom), 1'b0);
			end else if (r < (wide_rows ? 60 : 74)) begin
				send_word(WORD_END_ROW, rs);
			end else if (r < 84) begin
				send_word(WORD_SKIP, rs);
				hi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 2);
				send_word({8'(hi), 8'($urandom_range(0, 255))}, 1'b0);
			end else if (r < 87) begin
				send_word(WORD_END_IMAGE, rs);
			end else begin
				send_word(16'($urandom), rs);
			end
			rs = 1'b0;
		end
	endtask

	task automatic run_random_phase(input logic [11:0] w, input logic [11:0] h,
			input int unsigned count, input bit no_gaps, input bit long_rows);
		set_dims(w, h);
		steady = no_gaps;
		wide_rows = long_rows;
		send_random_words(count);
		steady = 1'b0;
		wide_rows = 1'b0;
	endtask

	task automatic test_ignored_before_restart();
		send_word(16'h0503, 1'b0);
		send_word(WORD_END_ROW, 1'b0);
		settle();
	endtask

	task automatic test_directed_spans();
		set_dims(12'd10, 12'd3);
		send_word(16'h0503, 1'b1);
		send_word(16'h0300, 1'b0);
		send_word(16'hBBAA, 1'b0);
		send_word(16'hEECC, 1'b0);
		send_word(16'hFF07, 1'b0);
		send_word(16'h0102, 1'b0);
		send_word(WORD_END_ROW, 1'b0);
		send_word(WORD_SKIP, 1'b0);
		send_word(16'h0004, 1'b0);
		send_word(16'h2201, 1'b0);
		send_word(WORD_SKIP, 1'b0);
		send_word(16'h0102, 1'b0);
		send_word(WORD_END_ROW, 1'b0);
		send_word(16'h0301, 1'b0);
		send_word(WORD_END_IMAGE, 1'b1);
		send_word(WORD_SKIP, 1'b1);
		send_word(16'h05FF, 1'b0);
		send_word(16'hFFFF, 1'b1);
	endtask

	task automatic test_zero_dimensions();
		set_dims(12'd0, 12'd2);
		send_word(16'h1105, 1'b1);
		send_word(16'h0300, 1'b0);
		send_word(16'h1234, 1'b0);
		send_word(16'h5678, 1'b0);
		send_word(WORD_END_ROW, 1'b0);
		send_word(WORD_END_ROW, 1'b0);
		set_dims(12'd7, 12'd0);
		send_word(16'hABCD, 1'b1);
	endtask

	task automatic test_backpressure();
		set_dims(12'd200, 12'd40);
		hold_off_req = 1'b1;
		steady = 1'b1;
		send_word(16'h3304, 1'b1);
		repeat (40) send_word({8'($urandom_range(0, 255)), 8'($urandom_range(1, 4))}, 1'b0);
		steady = 1'b0;
		settle();
		repeat (20) send_word({8'($urandom_range(0, 255)), 8'($urandom_range(1, 4))}, 1'b0);
	endtask

	task automatic test_random_images();
		run_random_phase(12'd1, 12'd1, 120, 1'b0, 1'b0);
		run_random_phase(12'd4095, 12'd4095, 300, 1'b0, 1'b1);
		run_random_phase(12'd16, 12'd6, 200, 1'b0, 1'b0);
		run_random_phase(12'd16, 12'd6, 120, 1'b1, 1'b0);
		run_random_phase(12'd3, 12'd2, 120, 1'b0, 1'b0);
		run_random_phase(12'($urandom_range(1, 80)), 12'($urandom_range(1, 20)), 200, 1'b0, 1'b0);
		run_random_phase(12'($urandom_range(1, 80)), 12'($urandom_range(1, 20)), 150, 1'b0, 1'b0);
		run_random_phase(12'd0, 12'd5, 60, 1'b0, 1'b0);
		run_random_phase(12'd40, 12'd0, 40, 1'b0, 1'b0);
	endtask

	initial begin : span_sink
		int unsigned stall;
		stall = 0;
		span_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end else if (stall == 0 && !steady) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				span_ch.ready <= 1'b0;
				stall--;
			end else begin
				span_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : span_check
		span_t want;
		if (span_ch.valid === 1'b1 && span_ch.ready === 1'b1) begin
			if (expected_spans.size() == 0) begin
				report_mismatch($sformatf("span with nothing expected: kind %0d col %0d row %0d",
					span_ch.span_kind, span_ch.col, span_ch.row));
			end else begin
				want = expected_spans.pop_front();
				check_field("span_kind", span_ch.span_kind, want.kind);
				check_field("col", span_ch.col, want.col);
				check_field("row", span_ch.row, want.row);
				check_field("span_length", span_ch.span_length, want.len);
				check_field("first_index", span_ch.first_index, want.first_idx);
				check_field("second_index", span_ch.second_index, want.second_idx);
				case (want.kind)
					KIND_FILL: fill_seen++;
					KIND_LITERAL: literal_seen++;
					default: done_seen++;
				endcase
			end
		end
	end

	// End the run if no item moves on either channel for too long
	always @(posedge clk) begin
		if ((code_ch.valid === 1'b1 && code_ch.ready === 1'b1) ||
				(span_ch.valid === 1'b1 && span_ch.ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("timeout: no item moved for %0d cycles, %0d spans outstanding",
					QUIET_LIMIT, expected_spans.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_wdata <= '0;
		code_ch.valid <= 1'b0;
		code_ch.code_word <= '0;
		code_ch.restart <= 1'b0;
		dim_width = 12'd1;
		dim_height = 12'd1;
		row_pos = 0;
		col_pos = 0;
		run_left = 0;
		parse_ph = PH_CONTROL;
		image_closed = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_before_restart();
		test_directed_spans();
		test_zero_dimensions();
		test_backpressure();
		test_random_images();

		settle();
		repeat (10) @(posedge clk);
		$display("Decoded %0d coded words under %0d size settings.", words_decoded,
			settings_used);
		$display("Checked %0d fill, %0d literal and %0d end-of-image spans; %0d mismatches.",
			fill_seen, literal_seen, done_seen, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
src/sprd_pkg.sv
src/sprd_word_if.sv
src/sprd_span_if.sv
src/sprite_rle_word_decoder.sv
tb/tb_sprite_rle_word_decoder.sv
